// ===== src/altitude_layer_interpolator_defines.svh =====
// assertion macros for the altitude layer interpolator
`ifndef ALTITUDE_LAYER_INTERPOLATOR_DEFINES_SVH
`define ALTITUDE_LAYER_INTERPOLATOR_DEFINES_SVH

// a condition that must hold at every edge outside reset
`define ALI_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// an antecedent that forces a consequent in the next cycle
`define ALI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ali_pkg.sv =====
`timescale 1ns / 1ps
package ali_pkg;

   localparam int MaxLayersDefault    = 16;
   localparam int FractionBitsDefault = 16;

   localparam int AltWidth   = 17;
   localparam int ValueWidth = 16;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_WR,
      ST_Q_RD0,
      ST_Q_SCAN,
      ST_Q_RDHI,
      ST_Q_DIV,
      ST_Q_MUL,
      ST_Q_DONE
   } state_type;

   // one table row
   typedef struct packed {
      logic signed [AltWidth-1:0]   alt;
      logic signed [ValueWidth-1:0] east;
      logic signed [ValueWidth-1:0] north;
      logic signed [ValueWidth-1:0] temp;
   } row_type;

   // memory port command from the sequencer
   typedef struct packed {
      logic we;
      logic re;
   } mem_ctl_type;

endpackage

// ===== src/ali_table_ram.sv =====
`timescale 1ns / 1ps
module ali_table_ram #(
   parameter int Depth = 16,
   parameter int AddrWidth = 4
) (
   input  logic                     clock,
   input  ali_pkg::mem_ctl_type     ctl,
   input  logic [AddrWidth-1:0]     wr_addr,
   input  ali_pkg::row_type         wr_data,
   input  logic [AddrWidth-1:0]     rd_addr,
   output ali_pkg::row_type         rd_data
);
   import ali_pkg::*;

   row_type mem [Depth];
   row_type rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/ali_divider.sv =====
`timescale 1ns / 1ps
module ali_divider #(
   parameter int FracBits = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [17:0]                   num,
   input  logic [17:0]                   den,
   output logic                          done,
   output logic [FracBits:0]             quot
);
   import ali_pkg::*;

   localparam int QW = FracBits + 1;
   localparam int CW = $clog2(QW + 1);

   logic [18:0]     rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic [18:0]     shifted;
   logic [18:0]     trial;

   // restoring divide, one quotient bit per cycle; num <= den so rem starts as num
   // the first step compares num itself, so a fraction of exactly one fits
   always_comb begin
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      shifted = (cnt_ff == CW'(FracBits)) ? {1'b0, rem_ff[17:0]} : {rem_ff[17:0], 1'b0};
      trial  = shifted - {1'b0, den};
      if (go) begin
         rem_in = {1'b0, num};
         q_in   = '0;
         cnt_in = CW'(FracBits);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[18]) begin
            rem_in = trial;
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = run_ff && cnt_ff == '0;
   assign quot = q_in;
endmodule

// ===== src/altitude_layer_interpolator.sv =====
`timescale 1ns / 1ps
// channel   | ports                                     | handshake
// request   | req_mode req_altitude req_east_wind ...   | start high, busy low
// response  | rsp_status rsp_east_out ... layer_count   | rsp_valid one cycle
//
// clear, full insert, empty query and unused mode 3 go straight to the result;
// insert reads downward from the top, shifting each higher row up by one, then
// writes the new row; query reads the last row, then the first, scans upward
// to the bracketing pair and, unless the query lies at or beyond an end row,
// runs the serial divide and blends. the memory port does one read, one write a cycle.
// reset is synchronous; it empties the table, memory contents stay.
// busy is high from accept until the result strobe, when the next word may be
// taken; results cannot be stalled.
module altitude_layer_interpolator #(
   parameter int MAX_LAYERS    = ali_pkg::MaxLayersDefault,
   parameter int FRACTION_BITS = ali_pkg::FractionBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic signed [16:0]  req_altitude,
   input  logic signed [15:0]  req_east_wind,
   input  logic signed [15:0]  req_north_wind,
   input  logic signed [15:0]  req_temp_offset,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic signed [15:0]  rsp_east_out,
   output logic signed [15:0]  rsp_north_out,
   output logic signed [15:0]  rsp_temp_out,
   output logic [4:0]          rsp_layer_count
);
   import ali_pkg::*;
   `include "altitude_layer_interpolator_defines.svh"

   localparam int AW = $clog2(MAX_LAYERS);
   localparam int CW = $clog2(MAX_LAYERS + 1);
   localparam int FB = FRACTION_BITS;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   row_type req_ff, req_in;
   row_type lo_ff, lo_in;
   logic top_ff, top_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic signed [15:0] e_ff, e_in, n_ff, n_in, t_ff, t_in;

   mem_ctl_type mctl;
   logic [AW-1:0] wr_addr, rd_addr;
   row_type wr_data, rd_data;
   logic div_go, div_done;
   logic [FB:0] quot;
   logic [FB:0] frac_ff, frac_in;
   logic [17:0] num, den;

   ali_table_ram #(.Depth(MAX_LAYERS), .AddrWidth(AW)) u_ram (
      .clock(clock), .ctl(mctl), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign num = 18'(signed'(req_ff.alt) - signed'(lo_ff.alt));
   assign den = 18'(signed'(rd_data.alt) - signed'(lo_ff.alt));

   ali_divider #(.FracBits(FB)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(num), .den(den),
      .done(div_done), .quot(quot));

   // blend of one value: v0 + round(t*(v1-v0))
   function automatic logic signed [15:0] blend(input logic signed [15:0] v0,
                                                input logic signed [15:0] v1,
                                                input logic [FB:0] t);
      logic signed [17:0] d;
      logic signed [FB+19:0] p;
      d = 18'(v1) - 18'(v0);
      p = signed'({1'b0, t}) * d + (FB+20)'(1 <<< (FB-1));
      return 16'(v0 + 16'(p >>> FB));
   endfunction

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      req_in   = req_ff;
      lo_in    = lo_ff;
      top_in   = top_ff;
      frac_in  = frac_ff;
      rsp_valid_in = 1'b0;
      status_in = status_ff;
      e_in = e_ff; n_in = n_ff; t_in = t_ff;
      mctl = '0;
      wr_addr = '0; rd_addr = '0;
      wr_data = req_ff;
      div_go = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = '{req_altitude, req_east_wind, req_north_wind, req_temp_offset};
               status_in = STATUS_OK;
               e_in = '0; n_in = '0; t_in = '0;
               unique case (mode_type'(req_mode))
                  MODE_CLEAR: begin
                     count_in = '0;
                     state_in = ST_Q_DONE;
                  end
                  MODE_INSERT: begin
                     if (count_ff >= CW'(MAX_LAYERS)) begin
                        status_in = STATUS_FULL;
                        state_in = ST_Q_DONE;
                     end else begin
                        pos_in = count_ff;
                        state_in = ST_INS_RD;
                     end
                  end
                  MODE_QUERY: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in = ST_Q_DONE;
                     end else begin
                        pos_in = '0;
                        state_in = ST_Q_RDHI;
                     end
                  end
                  default: state_in = ST_Q_DONE;
               endcase
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               state_in = ST_INS_WR;
            end else begin
               mctl.re = 1'b1;
               rd_addr = AW'(pos_ff - 1'b1);
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (signed'(rd_data.alt) > signed'(req_ff.alt)) begin
               mctl.we = 1'b1;
               wr_addr = AW'(pos_ff);
               wr_data = rd_data;
               pos_in = pos_ff - 1'b1;
               state_in = ST_INS_RD;
            end else begin
               state_in = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            mctl.we = 1'b1;
            wr_addr = AW'(pos_ff);
            count_in = count_ff + 1'b1;
            state_in = ST_Q_DONE;
         end
         // fetch the last row first
         ST_Q_RDHI: begin
            mctl.re = 1'b1;
            rd_addr = AW'(count_ff - 1'b1);
            state_in = ST_Q_RD0;
         end
         // last row is loaded as the result; it stands when the query lies at or above it and above the first row
         ST_Q_RD0: begin
            top_in = signed'(req_ff.alt) >= signed'(rd_data.alt);
            e_in = rd_data.east; n_in = rd_data.north; t_in = rd_data.temp;
            mctl.re = 1'b1;
            rd_addr = '0;
            state_in = ST_Q_SCAN;
         end
         // scan: pos is the row now in rd_data, read in the previous cycle
         ST_Q_SCAN: begin
            if (pos_ff == '0 && (count_ff == CW'(1) ||
                signed'(req_ff.alt) <= signed'(rd_data.alt))) begin
               e_in = rd_data.east; n_in = rd_data.north; t_in = rd_data.temp;
               state_in = ST_Q_DONE;
            end else if (top_ff) begin
               state_in = ST_Q_DONE;
            end else if (pos_ff == count_ff - 1'b1) begin
               if (signed'(req_ff.alt) >= signed'(rd_data.alt)) begin
                  e_in = rd_data.east; n_in = rd_data.north; t_in = rd_data.temp;
                  state_in = ST_Q_DONE;
               end else begin
                  state_in = ST_Q_DIV;
                  div_go = 1'b1;
               end
            end else if (pos_ff != '0 &&
                         signed'(req_ff.alt) <= signed'(rd_data.alt)) begin
               state_in = ST_Q_DIV;
               div_go = 1'b1;
            end else begin
               lo_in = rd_data;
               pos_in = pos_ff + 1'b1;
               mctl.re = 1'b1;
               rd_addr = AW'(pos_ff + 1'b1);
            end
         end
         ST_Q_DIV: begin
            if (div_done) begin
               frac_in = quot;
               state_in = ST_Q_MUL;
            end
         end
         ST_Q_MUL: begin
            e_in = blend(lo_ff.east, rd_data.east, frac_ff);
            n_in = blend(lo_ff.north, rd_data.north, frac_ff);
            t_in = blend(lo_ff.temp, rd_data.temp, frac_ff);
            state_in = ST_Q_DONE;
         end
         ST_Q_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      req_ff <= req_in;
      lo_ff <= lo_in;
      top_ff <= top_in;
      frac_ff <= frac_in;
      status_ff <= status_in;
      e_ff <= e_in; n_ff <= n_in; t_ff <= t_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_east_out = e_ff;
   assign rsp_north_out = n_ff;
   assign rsp_temp_out = t_ff;
   assign rsp_layer_count = 5'(count_ff);

   `ALI_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(MAX_LAYERS), "count over depth")
   `ALI_ASSERT_ALWAYS(a_rsp_when_idle, clock, reset, !rsp_valid || !busy, "busy during result")
   `ALI_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "idle after accept")
   `ALI_ASSERT_ALWAYS(a_no_write_query, clock, reset, !(mctl.we && state_ff == ST_Q_SCAN), "write during query")
endmodule
